// ===== rtl/pmtl_pkg.sv =====
package pmtl_pkg;

	localparam int FRAME_WIDTH_DEF  = 352;
	localparam int FRAME_HEIGHT_DEF = 240;

	localparam int NUM_LABELS          = 3;
	localparam int DIV_STEPS_PER_STAGE = 8;
	localparam int FIFO_DEPTH          = 8;
	localparam int FIFO_PTR_W          = $clog2(FIFO_DEPTH);
	localparam int OCC_W               = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0]  LABEL_MAX  = 2'd2;
	localparam logic [15:0] Q15_ONE    = 16'd32768;
	localparam logic [15:0] Q15_THIRD  = 16'd10923;
	localparam logic [15:0] Q15_HALF   = 16'd16384;
	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [8:0] col;
		logic [7:0] row_index;
		logic [1:0] label;
		logic       first_frame;
	} pmtl_in_t;

	typedef struct packed {
		logic [8:0]  out_col;
		logic [7:0]  out_row;
		logic [1:0]  prev_label;
		logic        updated;
		logic [15:0] prob_to_zero;
		logic [15:0] prob_to_one;
		logic [15:0] prob_to_two;
		logic [15:0] obs_count_out;
	} pmtl_out_t;

	// All state of one pixel, kept as one memory word.
	typedef struct packed {
		logic [1:0]            last_label;
		logic [2:0][15:0]      cnt;
		logic [2:0][2:0][15:0] prob;
	} pix_word_t;

	// Restoring divider state: partial remainder, remaining dividend bits, quotient.
	typedef struct packed {
		logic [16:0] rem;
		logic [15:0] num;
		logic [15:0] quo;
	} div_t;

	// Per-item control and echo fields carried down the pipeline.
	typedef struct packed {
		logic        inframe;
		logic        first;
		logic [1:0]  label;
		logic [1:0]  pl;
		logic [15:0] cnt;
		logic [8:0]  col;
		logic [7:0]  row;
	} ctl_t;

	function automatic pix_word_t reset_word();
		pix_word_t w;
		w.last_label = 2'd0;
		w.cnt        = '0;
		for (int r = 0; r < NUM_LABELS; r++) begin
			for (int k = 0; k < NUM_LABELS; k++) begin
				w.prob[r][k] = Q15_THIRD;
			end
		end
		return w;
	endfunction

	function automatic logic [1:0] sat_label(input logic [1:0] l);
		return (l > LABEL_MAX) ? LABEL_MAX : l;
	endfunction

endpackage

// ===== rtl/pixel_markov_transition_learner_core.sv =====
// Per-pixel online Markov transition learner.
// Input requests carry one pixel's class label with its column and row. Each pixel
// owns one word in an on-chip memory holding its previous label, three observation
// counts and a 3x3 Q1.15 transition matrix. An in-frame request that is not a
// first-frame request increments the count of the previous label's row, derives
// alpha = round(32768 / count) with a two-stage restoring divider, decays that row
// by (1 - alpha), adds alpha to the current label's entry and writes the word back.
// Both channels use valid/ready. A new request may be accepted every cycle, so the
// sustained rate is one item per cycle while ready stays high. The pipeline is
// read, count, divide, divide, multiply, write back. A request for the same pixel
// as one still in the pipeline is held off by ready until the older one has been
// written back. Results enter an eight-entry output queue. Ready also drops when
// the queue plus the requests in flight already fill it, so a stalled receiver
// never loses a result. After reset the block sweeps the memory once, one pixel
// per cycle, writing the initial counts and one-third probabilities; ready stays
// low during the sweep.
module pixel_markov_transition_learner_core #(
	parameter int FRAME_WIDTH  = pmtl_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = pmtl_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pmtl_pkg::pmtl_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pmtl_pkg::pmtl_out_t out_data
);
	import pmtl_pkg::*;

	localparam int NPIX   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = (NPIX > 1) ? $clog2(NPIX) : 1;

	// Pixel memory, one word per pixel, one read and one write port.
	pix_word_t mem_q [NPIX];

	logic              accept, pop, hazard, inframe_in;
	logic [ADDR_W-1:0] addr_in;

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3, addr_s4, addr_s5, addr_s6;
	pix_word_t         word_s2, word_s3, word_s4, word_s5, word_s6;
	div_t              div_s3, div_s4, div_s5, div_mid, div_end;
	logic [2:0][31:0]  prod_s6;
	logic [15:0]       alpha_s6;

	logic [1:0]        pl_c;
	logic [15:0]       cnt_c, cnt_old_c, keep_c;
	ctl_t              ctl_c;

	pix_word_t         wword;
	pmtl_out_t         res;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	pix_word_t         mem_wdata;

	pmtl_out_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0]       fifo_cnt_q, occ_q;
	logic                   push;

	// Address of the incoming request and the check against pixels in flight.
	assign inframe_in = (32'(in_data.col) < 32'(FRAME_WIDTH))
		&& (32'(in_data.row_index) < 32'(FRAME_HEIGHT));
	assign addr_in = ADDR_W'(32'(in_data.row_index) * 32'(FRAME_WIDTH) + 32'(in_data.col));

	always_comb begin
		hazard = 1'b0;
		if (inframe_in) begin
			hazard = (v_s1 && ctl_s1.inframe && addr_s1 == addr_in)
				|| (v_s2 && ctl_s2.inframe && addr_s2 == addr_in)
				|| (v_s3 && ctl_s3.inframe && addr_s3 == addr_in)
				|| (v_s4 && ctl_s4.inframe && addr_s4 == addr_in)
				|| (v_s5 && ctl_s5.inframe && addr_s5 == addr_in)
				|| (v_s6 && ctl_s6.inframe && addr_s6 == addr_in);
		end
	end

	assign in_ready = !clearing_q && !hazard && (occ_q < OCC_W'(FIFO_DEPTH));
	assign accept   = in_valid && in_ready;

	// Valid bits of the pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1 captures the request; the memory read is launched from it.
	always_ff @(posedge clk) begin
		ctl_s1.inframe <= inframe_in;
		ctl_s1.first   <= in_data.first_frame;
		ctl_s1.label   <= sat_label(in_data.label);
		ctl_s1.pl      <= 2'd0;
		ctl_s1.cnt     <= '0;
		ctl_s1.col     <= in_data.col;
		ctl_s1.row     <= in_data.row_index;
		addr_s1        <= addr_in;
	end

	always_ff @(posedge clk) begin
		word_s2 <= mem_q[addr_s1];
		ctl_s2  <= ctl_s1;
		addr_s2 <= addr_s1;
	end

	// Stage 2: select the previous label's row and bump its count.
	always_comb begin
		pl_c      = sat_label(word_s2.last_label);
		cnt_old_c = word_s2.cnt[pl_c];
		cnt_c     = (cnt_old_c == COUNT_MAX) ? COUNT_MAX : cnt_old_c + 16'd1;
		ctl_c     = ctl_s2;
		ctl_c.pl  = pl_c;
		ctl_c.cnt = cnt_c;
	end

	always_ff @(posedge clk) begin
		ctl_s3     <= ctl_c;
		word_s3    <= word_s2;
		addr_s3    <= addr_s2;
		div_s3.rem <= '0;
		div_s3.num <= Q15_ONE + {1'b0, cnt_c[15:1]};
		div_s3.quo <= '0;
	end

	// Stages 3 and 4: rounded quotient 32768 / count, eight bits per stage.
	pmtl_div_step8 u_div_hi (
		.din     (div_s3),
		.divisor (ctl_s3.cnt),
		.dout    (div_mid)
	);

	always_ff @(posedge clk) begin
		ctl_s4  <= ctl_s3;
		word_s4 <= word_s3;
		addr_s4 <= addr_s3;
		div_s4  <= div_mid;
	end

	pmtl_div_step8 u_div_lo (
		.din     (div_s4),
		.divisor (ctl_s4.cnt),
		.dout    (div_end)
	);

	always_ff @(posedge clk) begin
		ctl_s5  <= ctl_s4;
		word_s5 <= word_s4;
		addr_s5 <= addr_s4;
		div_s5  <= div_end;
	end

	// Stage 5: scale the selected row by (1 - alpha).
	assign keep_c = Q15_ONE - div_s5.quo;

	always_ff @(posedge clk) begin
		ctl_s6   <= ctl_s5;
		word_s6  <= word_s5;
		addr_s6  <= addr_s5;
		alpha_s6 <= div_s5.quo;
		for (int k = 0; k < NUM_LABELS; k++) begin
			prod_s6[k] <= 32'(word_s5.prob[ctl_s5.pl][k]) * 32'(keep_c);
		end
	end

	// Stage 6: round, add alpha to the current label's entry, write back and report.
	always_comb begin
		logic [31:0]      rounded;
		logic [16:0]      sum;
		logic [2:0][15:0] newrow;
		for (int k = 0; k < NUM_LABELS; k++) begin
			rounded = prod_s6[k] + 32'(Q15_HALF);
			sum     = {1'b0, rounded[30:15]};
			if (ctl_s6.label == 2'(k)) begin
				sum = sum + {1'b0, alpha_s6};
			end
			newrow[k] = (sum > {1'b0, Q15_ONE}) ? Q15_ONE : sum[15:0];
		end

		wword            = word_s6;
		wword.last_label = ctl_s6.label;
		res              = '0;
		res.out_col      = ctl_s6.col;
		res.out_row      = ctl_s6.row;
		if (ctl_s6.first) begin
			wword.cnt = '0;
		end else begin
			wword.cnt[ctl_s6.pl]  = ctl_s6.cnt;
			wword.prob[ctl_s6.pl] = newrow;
			if (ctl_s6.inframe) begin
				res.prev_label    = ctl_s6.pl;
				res.updated       = 1'b1;
				res.prob_to_zero  = newrow[0];
				res.prob_to_one   = newrow[1];
				res.prob_to_two   = newrow[2];
				res.obs_count_out = ctl_s6.cnt;
			end
		end
	end

	// The single write port serves both the clearing sweep and write-back.
	assign mem_we    = clearing_q || (v_s6 && ctl_s6.inframe);
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s6;
	assign mem_wdata = clearing_q ? reset_word() : wword;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(NPIX - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Output queue. occ_q counts requests in flight plus queued results.
	assign push      = v_s6;
	assign pop       = out_valid && out_ready;
	assign out_valid = (fifo_cnt_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			occ_q      <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + OCC_W'(push) - OCC_W'(pop);
			occ_q      <= occ_q + OCC_W'(accept) - OCC_W'(pop);
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(FIFO_DEPTH))
		else $error("in-flight count exceeds output queue depth");

	a_queue_within_occ: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= occ_q)
		else $error("queued results exceed accepted requests");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !accept)
		else $error("request accepted during memory clearing");

	a_no_writeback_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !v_s6)
		else $error("write-back collides with clearing sweep");

	a_no_same_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && inframe_in) |=> !(v_s2 && ctl_s2.inframe && addr_s2 == addr_s1))
		else $error("two requests for one pixel in flight");

endmodule

// ===== rtl/pmtl_div_step8.sv =====
module pmtl_div_step8 (
	input  pmtl_pkg::div_t din,
	input  logic [15:0]    divisor,
	output pmtl_pkg::div_t dout
);
	import pmtl_pkg::*;

	div_t        st;
	logic [16:0] trial;

	// Eight restoring division steps, one quotient bit each.
	always_comb begin
		st    = din;
		trial = '0;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			trial  = {st.rem[15:0], st.num[15]};
			st.num = {st.num[14:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				st.rem = trial - {1'b0, divisor};
				st.quo = {st.quo[14:0], 1'b1};
			end else begin
				st.rem = trial;
				st.quo = {st.quo[14:0], 1'b0};
			end
		end
		dout = st;
	end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import pmtl_pkg::*;

	localparam int FW = FRAME_WIDTH_DEF;
	localparam int FH = FRAME_HEIGHT_DEF;
	localparam int NPIX = FW * FH;
	// The watchdog must outlast the clearing sweep after reset (one pixel per cycle)
	// by a wide margin.
	localparam int IDLE_LIMIT = 3 * NPIX;
	localparam int RANDOM_ITEMS = 1600;
	// A small working set of pixels keeps counts growing so that alpha gets small.
	localparam int HOT_PIX = 24;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pmtl_in_t in_data;
	logic out_valid;
	logic out_ready;
	pmtl_out_t out_data;

	// The learner state mirrored per pixel. Pixels are tracked sparsely in
	// associative arrays; an entry that is absent holds its reset value.
	class transition_scoreboard;
		logic [1:0] last_label [int];
		logic [15:0] counts [int];
		logic [15:0] probs [int];
		pmtl_out_t expected_rows[$];
		int mismatches;

		function logic [15:0] count_of(int idx);
			return counts.exists(idx) ? counts[idx] : 16'd0;
		endfunction

		function logic [15:0] prob_of(int idx);
			return probs.exists(idx) ? probs[idx] : Q15_THIRD;
		endfunction

		// Works out the row update that one accepted request causes.
		function void note_request(pmtl_in_t req);
			pmtl_out_t res;
			int pix;
			int lab;
			int pl;
			int cnt;
			int alpha;
			int keep;
			int e;
			logic [15:0] entry [3];
			res = '0;
			res.out_col = req.col;
			res.out_row = req.row_index;
			lab = (req.label > LABEL_MAX) ? LABEL_MAX : req.label;
			if (req.col < FW && req.row_index < FH) begin
				pix = req.row_index * FW + req.col;
				if (req.first_frame) begin
					for (int r = 0; r < 3; r++) counts[pix * 3 + r] = 16'd0;
					last_label[pix] = 2'(lab);
				end else begin
					pl = last_label.exists(pix) ? last_label[pix] : 0;
					cnt = count_of(pix * 3 + pl);
					if (cnt < 65535) cnt++;
					counts[pix * 3 + pl] = 16'(cnt);
					alpha = (32768 + (cnt >> 1)) / cnt;
					keep = 32768 - alpha;
					for (int k = 0; k < 3; k++) begin
						e = (prob_of(pix * 9 + pl * 3 + k) * keep + 16384) >> 15;
						entry[k] = 16'(e);
					end
					e = entry[lab] + alpha;
					entry[lab] = (e > 32768) ? 16'd32768 : e[15:0];
					for (int k = 0; k < 3; k++) probs[pix * 9 + pl * 3 + k] = entry[k];
					last_label[pix] = 2'(lab);
					res.prev_label = 2'(pl);
					res.updated = 1'b1;
					res.prob_to_zero = entry[0];
					res.prob_to_one = entry[1];
					res.prob_to_two = entry[2];
					res.obs_count_out = 16'(cnt);
				end
			end
			expected_rows.insert(expected_rows.size(), res);
		endfunction

		function void check_result(pmtl_out_t got);
			pmtl_out_t want;
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %p", got);
				return;
			end
			want = expected_rows.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	transition_scoreboard board;
	int idle_cycles;
	bit timed_out;

	// Pixels that have had a first-frame request, so the stimulus never
	// reads a previous label that was never written.
	bit seeded [int];
	int hot_col [HOT_PIX];
	int hot_row [HOT_PIX];

	pixel_markov_transition_learner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Results are checked at the edge where they are accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	// Receiver stalls: a repeating mode switch between always-ready, light and
	// heavy backpressure.
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			case ((stall_phase / 200) % 3)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= ($urandom_range(3) != 0);
				end
				default: begin
					out_ready <= ($urandom_range(3) == 0);
				end
			endcase
		end
	end

	// Any cycle with no accepted request or result counts toward the watchdog.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Presents one request and holds it until it is accepted.
	task automatic send_request(input pmtl_in_t req);
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(req);
		if (req.first_frame && req.col < FW && req.row_index < FH)
			seeded[req.row_index * FW + req.col] = 1'b1;
	endtask

	// A gap length of zero leaves the sender's outputs alone.
	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			in_data <= pmtl_in_t'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic pmtl_in_t make_request(input int c, input int r, input int l,
			input bit first);
		pmtl_in_t req;
		req.col = 9'(c);
		req.row_index = 8'(r);
		req.label = 2'(l);
		req.first_frame = first;
		return req;
	endfunction

	// Picks one request: mostly updates of seeded hot pixels, with restarts,
	// out-of-frame positions and fully random noise mixed in.
	function automatic pmtl_in_t random_request();
		int h;
		int sel;
		h = $urandom_range(HOT_PIX - 1);
		sel = $urandom_range(99);
		if (sel < 75)
			return make_request(hot_col[h], hot_row[h], $urandom_range(3), 1'b0);
		if (sel < 82)
			return make_request(hot_col[h], hot_row[h], $urandom_range(3), 1'b1);
		if (sel < 90)
			return make_request($urandom_range(511), $urandom_range(255),
				$urandom_range(3), 1'b1);
		if (sel < 96)
			return make_request($urandom_range(FW, 511), $urandom_range(255),
				$urandom_range(3), $urandom_range(1));
		return make_request($urandom_range(511), $urandom_range(FH, 255),
			$urandom_range(3), $urandom_range(1));
	endfunction

	initial begin
		pmtl_in_t req;
		int sent;
		int burst;
		board = new();
		timed_out = 1'b0;
		idle_cycles = 0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners of the frame, restarts with each label, all transitions but
		// zero to two and two to one, label three included, and positions outside the frame.
		send_request(make_request(0, 0, 0, 1'b1));
		send_request(make_request(FW - 1, FH - 1, 3, 1'b1));
		send_request(make_request(0, 0, 1, 1'b0));
		send_request(make_request(0, 0, 2, 1'b0));
		send_request(make_request(0, 0, 3, 1'b0));
		send_request(make_request(0, 0, 0, 1'b0));
		send_request(make_request(FW - 1, FH - 1, 0, 1'b0));
		send_request(make_request(FW - 1, FH - 1, 0, 1'b0));
		send_request(make_request(FW - 1, FH - 1, 1, 1'b0));
		send_request(make_request(FW, 0, 1, 1'b0));
		send_request(make_request(511, 255, 3, 1'b1));
		send_request(make_request(0, FH, 2, 1'b1));
		send_request(make_request(0, 0, 1, 1'b1));
		send_request(make_request(0, 0, 1, 1'b0));
		// Back-to-back requests for one pixel exercise the same-pixel hold-off.
		for (int k = 0; k < 6; k++) send_request(make_request(0, 0, k % 3, 1'b0));

		// Seed the hot pixels, including the frame extremes.
		for (int h = 0; h < HOT_PIX; h++) begin
			hot_col[h] = (h == 0) ? FW - 1 : (h == 1) ? 0 : $urandom_range(FW - 1);
			hot_row[h] = (h == 0) ? 0 : (h == 1) ? FH - 1 : $urandom_range(FH - 1);
			send_request(make_request(hot_col[h], hot_row[h], $urandom_range(3), 1'b1));
		end

		// Random requests in bursts separated by random gaps.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(40, 1);
			for (int k = 0; k < burst; k++) begin
				req = random_request();
				if (!req.first_frame && req.col < FW && req.row_index < FH
						&& !seeded.exists(req.row_index * FW + req.col))
					req.first_frame = 1'b1;
				send_request(req);
				sent++;
			end
			idle_gap($urandom_range(3) == 0 ? 0 : $urandom_range(12, 1));
		end
		in_valid <= 1'b0;

		// Drain: wait on the expectation queue, then keep waiting for stray results.
		while (board.expected_rows.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.expected_rows.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pmtl_pkg.sv
rtl/pmtl_div_step8.sv
rtl/pixel_markov_transition_learner_core.sv
sim/tb_top.sv
